// ===== hw/rtl/ri2a_pkg.sv =====
// ----------------------------------------------------------------------------
// ri2a_pkg: shared types and constants
// Item and result formats, item kinds, divider step sizing and the digit
// character map of the integer to ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ri2a_pkg;

   localparam int VALUE_W  = 32;
   localparam int RADIX_W  = 6;
   localparam int CHAR_W   = 7;
   localparam int COUNT_W  = 6;
   localparam int STORE_W  = 8;

   // Radix limits
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   // Characters
   localparam logic [STORE_W-1:0] CHAR_ZERO = 8'd48;   // '0'
   localparam logic [STORE_W-1:0] CHAR_A    = 8'd65;   // 'A'
   localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

   // Divider: quotient bits resolved per cycle
   localparam int STEP_BITS  = 8;
   localparam int DIV_CYCLES = VALUE_W / STEP_BITS;
   localparam int STEP_W     = $clog2(DIV_CYCLES);

   // Result queue
   localparam int RSP_DEPTH = 2;
   localparam int LEVEL_W   = 2;

   // Item kinds decided at the front
   localparam logic [1:0] KIND_NUM  = 2'd0;
   localparam logic [1:0] KIND_ZERO = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic [1:0]         kind;
   } item_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  character;
      logic               last;
      logic [COUNT_W-1:0] digit_count;
      logic               bad_radix;
   } rsp_type;

   // Digit value to ASCII: 0-9 then A-Z
   function automatic logic [STORE_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      logic [STORE_W-1:0] ch;
      if (d < DIGIT_TEN) begin
         ch = CHAR_ZERO + {2'b00, d};
      end else begin
         ch = CHAR_A + {2'b00, d - DIGIT_TEN};
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ri2a_ram.sv =====
// ----------------------------------------------------------------------------
// ri2a_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ri2a_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ri2a_front.sv =====
// ----------------------------------------------------------------------------
// ri2a_front: request intake
// Classifies each request (number, zero, bad radix) and holds up to two
// classified items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ri2a_front
   import ri2a_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [RADIX_W-1:0] req_radix,
   output logic                    item_valid,
   output item_type                item,
   input  wire logic               item_take
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       do_push;
   logic       do_pop;

   // Classification
   always_comb begin
      new_item.value = req_value;
      new_item.radix = req_radix;
      priority if (req_radix < RADIX_MIN || req_radix > RADIX_MAX) begin
         new_item.kind = KIND_BAD;
      end else if (req_value == '0) begin
         new_item.kind = KIND_ZERO;
      end else begin
         new_item.kind = KIND_NUM;
      end
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = req_push && !req_full;
   assign do_pop     = item_take && item_valid;

   // Pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   // Back end only takes what is there
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      item_take |-> item_valid)
      else $error("front: item taken from an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/ri2a_back.sv =====
// ----------------------------------------------------------------------------
// ri2a_back: conversion engine
// Iterative divider producing the digits, least significant first, into
// the digit store, then a reader that emits the digits most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module ri2a_back
   import ri2a_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire item_type           item,
   output logic                    item_take,
   input  wire logic [LEVEL_W-1:0] rsp_level,
   output logic                    rsp_push,
   output rsp_type                 rsp
);

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIV    = 2'd1;
   localparam logic [1:0] S_EMIT   = 2'd2;
   localparam logic [1:0] S_DIRECT = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [VALUE_W-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic               inflight_ff, inflight_in;
   logic               rd_last_ff, rd_last_in;
   logic [COUNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   rsp_type            direct_ff, direct_in;

   logic [VALUE_W-1:0] div_quo_c;
   logic [RADIX_W-1:0] div_rem_c;
   logic               space;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [STORE_W-1:0] wr_data;
   logic               rd_en;
   logic [STORE_W-1:0] rd_data;

   // Divider: STEP_BITS restoring steps per cycle on a narrow remainder
   always_comb begin
      logic [RADIX_W:0]   t;
      logic [RADIX_W-1:0] r;
      logic [VALUE_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         t = {r, q[VALUE_W-1]};
         q = {q[VALUE_W-2:0], 1'b0};
         if (t >= {1'b0, radix_ff}) begin
            t    = t - {1'b0, radix_ff};
            q[0] = 1'b1;
         end
         r = t[RADIX_W-1:0];
      end
      div_quo_c = q;
      div_rem_c = r;
   end

   // Room in the result queue, counting a read still in flight
   assign space = ({1'b0, rsp_level} + {{LEVEL_W{1'b0}}, inflight_ff})
                  < (LEVEL_W+1)'(RSP_DEPTH);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      radix_in    = radix_ff;
      step_in     = step_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      inflight_in = 1'b0;
      rd_last_in  = rd_last_ff;
      rd_cnt_in   = rd_cnt_ff;
      direct_in   = direct_ff;
      item_take   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cnt_ff[AW-1:0];
      wr_data     = digit_char(div_rem_c);
      rd_en       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               quo_in    = item.value;
               radix_in  = item.radix;
               rem_in    = '0;
               step_in   = '0;
               cnt_in    = '0;
               if (item.kind == KIND_NUM) begin
                  state_in = S_DIV;
               end else if (item.kind == KIND_ZERO) begin
                  direct_in.character   = CHAR_ZERO[CHAR_W-1:0];
                  direct_in.last        = 1'b1;
                  direct_in.digit_count = COUNT_W'(1);
                  direct_in.bad_radix   = 1'b0;
                  state_in              = S_DIRECT;
               end else begin
                  direct_in.character   = '0;
                  direct_in.last        = 1'b1;
                  direct_in.digit_count = '0;
                  direct_in.bad_radix   = 1'b1;
                  state_in              = S_DIRECT;
               end
            end
         end
         S_DIV: begin
            if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
               // digit complete: store it and go on or finish
               wr_en  = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               if (div_quo_c == '0 || cnt_ff == CW'(MAX_DIGITS - 1)) begin
                  pos_in   = cnt_ff[AW-1:0];
                  state_in = S_EMIT;
               end else begin
                  quo_in  = div_quo_c;
                  rem_in  = '0;
                  step_in = '0;
               end
            end else begin
               quo_in  = div_quo_c;
               rem_in  = div_rem_c;
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_EMIT: begin
            if (space) begin
               rd_en       = 1'b1;
               inflight_in = 1'b1;
               rd_last_in  = (pos_ff == '0);
               rd_cnt_in   = cnt_ff[COUNT_W-1:0];
               if (pos_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff - AW'(1);
               end
            end
         end
         S_DIRECT: begin
            if (space && !inflight_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result transfer into the queue: store read return or direct result
   always_comb begin
      if (inflight_ff) begin
         rsp_push         = 1'b1;
         rsp.character    = rd_data[CHAR_W-1:0];
         rsp.last         = rd_last_ff;
         rsp.digit_count  = rd_last_ff ? rd_cnt_ff : '0;
         rsp.bad_radix    = 1'b0;
      end else begin
         rsp_push = (state_ff == S_DIRECT) && space;
         rsp      = direct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      radix_ff   <= radix_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      pos_ff     <= pos_in;
      rd_last_ff <= rd_last_in;
      rd_cnt_ff  <= rd_cnt_in;
      direct_ff  <= direct_in;
   end

   // Digit store
   ri2a_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   // Never push into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_level != LEVEL_W'(RSP_DEPTH)))
      else $error("back: result pushed into a full queue");

   // Partial remainder stays below the radix while dividing
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < radix_ff))
      else $error("back: remainder out of range");

   // A store read is only issued while emitting
   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> ($past(state_ff) == S_EMIT))
      else $error("back: read return without an emit cycle");

endmodule

`default_nettype wire

// ===== hw/rtl/ri2a_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// ri2a_rsp_queue: result queue
// Two-entry queue between the engine and the result port; presents the
// oldest result while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module ri2a_rsp_queue
   import ri2a_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire rsp_type             push_data,
   output logic [LEVEL_W-1:0]       level,
   output logic                     empty,
   input  wire logic                pop,
   output rsp_type                  head
);

   rsp_type             slot_ff [RSP_DEPTH];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                do_pop;

   assign level  = level_ff;
   assign empty  = (level_ff == '0);
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   // Pointer and level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      level_in  = level_ff + {{(LEVEL_W-1){1'b0}}, push}
                           - {{(LEVEL_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Level never passes the depth
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(RSP_DEPTH))
      else $error("rsp queue: level beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/radix_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: unsigned 32-bit integer to ASCII in radix 2..36
// Queue-style request and result ports; one result per character.
// ----------------------------------------------------------------------------
// Each request gives a 32-bit value and a radix; the block returns the digits
// most significant first as ASCII ('0'-'9', 'A'-'Z'), one result per
// character, with last and the digit count on the final one. A zero value
// returns '0'; a radix outside 2..36 returns a single result with bad_radix
// set and character 0. Up to two requests queue at the input. Conversion
// runs one request at a time: the single divider resolves 8 quotient bits
// per cycle into each digit, then each character is read back from the
// registered-read digit store as room in the two-entry result queue allows.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_ascii
   import ri2a_pkg::*;
#(
   parameter int MAX_DIGITS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [RADIX_W-1:0] req_radix,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic [CHAR_W-1:0]       rsp_character,
   output logic                    rsp_last,
   output logic [COUNT_W-1:0]      rsp_digit_count,
   output logic                    rsp_bad_radix
);

   item_type           item;
   logic               item_valid;
   logic               item_take;
   logic [LEVEL_W-1:0] rsp_level;
   logic               rsp_push;
   rsp_type            rsp_in;
   rsp_type            rsp_head;

   // Intake and classification
   ri2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_value  (req_value),
      .req_radix  (req_radix),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Conversion engine
   ri2a_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_level  (rsp_level),
      .rsp_push   (rsp_push),
      .rsp        (rsp_in)
   );

   // Result queue
   ri2a_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .level     (rsp_level),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_character   = rsp_head.character;
   assign rsp_last        = rsp_head.last;
   assign rsp_digit_count = rsp_head.digit_count;
   assign rsp_bad_radix   = rsp_head.bad_radix;

endmodule

`default_nettype wire
